[design/spmv_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmv_pkg: shared types and constants for the CSR sparse matrix-vector unit
// Holds action codes, field widths, the vector store geometry and the
// pipeline stage structs passed between the datapath modules.
// ---------------------------------------------------------------------------
package spmv_pkg;

  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 64;
  localparam int ROW_W     = 16;
  localparam int FRAC_W    = 16;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_MAC   = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // Item after the store read has been issued
  typedef struct packed {
    logic                    vld;
    logic [1:0]              act;
    logic                    in_rng;
    logic signed [VAL_W-1:0] value;
  } s1_t;

  // Item after the multiply
  typedef struct packed {
    logic                    vld;
    logic [1:0]              act;
    logic signed [ACC_W-1:0] prod;
  } s2_t;

endpackage

[design/spmv_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmv_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read; read data holds
// while the read enable is low.
// ---------------------------------------------------------------------------
module spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/spmv_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmv_mul: product stage
// Multiplies the nonzero value by the stored vector element and registers
// the exact Q32.32 product together with the item's control bits.
// ---------------------------------------------------------------------------
module spmv_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  spmv_pkg::s1_t                      s1,
  input  logic signed [spmv_pkg::VAL_W-1:0]  xdata,
  output spmv_pkg::s2_t                      s2
);

  spmv_pkg::s2_t                      s2_r;
  spmv_pkg::s2_t                      s2_nxt;
  logic signed [spmv_pkg::VAL_W-1:0]  xv;
  logic signed [spmv_pkg::ACC_W-1:0]  prod;

  // a column beyond the store contributes zero
  assign xv   = s1.in_rng ? xdata : '0;
  assign prod = spmv_pkg::ACC_W'(s1.value) * spmv_pkg::ACC_W'(xv);

  always_comb begin
    s2_nxt      = s2_r;
    if (adv) begin
      s2_nxt.vld  = s1.vld;
      s2_nxt.act  = s1.act;
      s2_nxt.prod = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
      s2_r.act <= spmv_pkg::ACT_LOAD;
    end else begin
      s2_r.vld <= s2_nxt.vld;
      s2_r.act <= s2_nxt.act;
    end
    s2_r.prod <= s2_nxt.prod;
  end

  assign s2 = s2_r;

endmodule

[design/spmv_acc.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmv_acc: row accumulator and result register
// Adds products into a saturating 64-bit row sum; a close-row item converts
// the sum to Q16.16, loads the result register, clears the sum and bumps the row counter.
// ---------------------------------------------------------------------------
module spmv_acc (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spmv_pkg::s2_t                      s2,
  output logic                               adv,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spmv_pkg::ROW_W-1:0]         out_row_number,
  output logic signed [spmv_pkg::VAL_W-1:0]  out_row_value,
  output logic                               out_overflow
);

  localparam int Q_W = spmv_pkg::ACC_W - spmv_pkg::FRAC_W;

  logic signed [spmv_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                              sat_r, sat_nxt;
  logic [spmv_pkg::ROW_W-1:0]        row_r, row_nxt;
  logic                              vld_r, vld_nxt;
  logic [spmv_pkg::ROW_W-1:0]        orow_r, orow_nxt;
  logic signed [spmv_pkg::VAL_W-1:0] oval_r, oval_nxt;
  logic                              oovf_r, oovf_nxt;

  logic signed [spmv_pkg::ACC_W-1:0] sum;
  logic                              add_ovf;
  logic signed [Q_W-1:0]             q;
  logic                              q_ovf;
  logic signed [spmv_pkg::VAL_W-1:0] q_sat;
  logic                              is_close;

  assign is_close = s2.vld && (s2.act == spmv_pkg::ACT_CLOSE);
  // hold everything while a close waits on a full result register
  assign adv      = !(is_close && vld_r && !out_ready);

  assign sum     = acc_r + s2.prod;
  assign add_ovf = (acc_r[spmv_pkg::ACC_W-1] == s2.prod[spmv_pkg::ACC_W-1]) &&
                   (sum[spmv_pkg::ACC_W-1] != acc_r[spmv_pkg::ACC_W-1]);

  // arithmetic shift right by the fraction width is a floor division
  assign q     = acc_r[spmv_pkg::ACC_W-1:spmv_pkg::FRAC_W];
  assign q_ovf = !((&q[Q_W-1:spmv_pkg::VAL_W-1]) || !(|q[Q_W-1:spmv_pkg::VAL_W-1]));
  assign q_sat = q_ovf ? (q[Q_W-1] ? {1'b1, {(spmv_pkg::VAL_W-1){1'b0}}}
                                   : {1'b0, {(spmv_pkg::VAL_W-1){1'b1}}})
                       : q[spmv_pkg::VAL_W-1:0];

  always_comb begin
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    row_nxt  = row_r;
    vld_nxt  = vld_r && !out_ready;
    orow_nxt = orow_r;
    oval_nxt = oval_r;
    oovf_nxt = oovf_r;
    if (adv && s2.vld) begin
      unique case (s2.act)
        spmv_pkg::ACT_MAC: begin
          if (add_ovf) begin
            acc_nxt = acc_r[spmv_pkg::ACC_W-1] ? {1'b1, {(spmv_pkg::ACC_W-1){1'b0}}}
                                               : {1'b0, {(spmv_pkg::ACC_W-1){1'b1}}};
            sat_nxt = 1'b1;
          end else begin
            acc_nxt = sum;
          end
        end
        spmv_pkg::ACT_CLOSE: begin
          vld_nxt  = 1'b1;
          orow_nxt = row_r;
          oval_nxt = q_sat;
          oovf_nxt = sat_r || q_ovf;
          acc_nxt  = '0;
          sat_nxt  = 1'b0;
          row_nxt  = row_r + 1'b1;
        end
        default: begin
          // loads and unused codes leave the row state alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
      row_r <= '0;
      vld_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
      row_r <= row_nxt;
      vld_r <= vld_nxt;
    end
    orow_r <= orow_nxt;
    oval_r <= oval_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_valid      = vld_r;
  assign out_row_number = orow_r;
  assign out_row_value  = oval_r;
  assign out_overflow   = oovf_r;

endmodule

[design/csr_sparse_matrix_vector_multiply.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply: y = A*x over a CSR-ordered item stream
// Loads the dense vector into a local store, multiplies streamed nonzeros by
// the stored elements and emits one saturated Q16.16 sum per closed row.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_action selects load vector element,
//   accumulate nonzero or close row; in_index is the element or column index;
//   in_value is the Q16.16 element or nonzero.
//   Result channel (out_valid/out_ready): one item per close-row item with
//   the row number, the saturated row sum and an overflow flag.
//   Throughput: one item per cycle, set by the single store read port and the
//   one multiply-accumulate per item, while the input is not stalled.
//   Pipeline: a close-row item passes the store read, multiply and
//   accumulate/convert stages in that order before its result shows.
//   Reset clears the row sum, row counter, saturation flag and all valid bits;
//   the vector store holds nothing defined until loaded.
//   When the receiver stalls, loads and nonzeros keep flowing; input stalls
//   only when a close-row item reaches the result register while it is full.
// ---------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_action,
  input  logic [spmv_pkg::IDX_W-1:0]         in_index,
  input  logic signed [spmv_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spmv_pkg::ROW_W-1:0]         out_row_number,
  output logic signed [spmv_pkg::VAL_W-1:0]  out_row_value,
  output logic                               out_overflow
);

  logic                              adv;
  logic                              accept;
  logic                              idx_ok;
  logic [spmv_pkg::VEC_AW-1:0]       addr;
  logic [spmv_pkg::VAL_W-1:0]        xdata;
  spmv_pkg::s1_t                     s1_r, s1_nxt;
  spmv_pkg::s2_t                     s2;

  assign in_ready = adv;
  assign accept   = in_valid && in_ready;
  assign idx_ok   = 32'(in_index) < 32'(spmv_pkg::VEC_DEPTH);
  assign addr     = spmv_pkg::VEC_AW'(in_index);

  spmv_ram #(
    .WIDTH (spmv_pkg::VAL_W),
    .DEPTH (spmv_pkg::VEC_DEPTH)
  ) u_vec (
    .clk   (clk),
    .we    (accept && (in_action == spmv_pkg::ACT_LOAD) && idx_ok),
    .waddr (addr),
    .wdata (in_value),
    .re    (accept),
    .raddr (addr),
    .rdata (xdata)
  );

  always_comb begin
    s1_nxt = s1_r;
    if (adv) begin
      s1_nxt.vld    = accept;
      s1_nxt.act    = in_action;
      s1_nxt.in_rng = idx_ok;
      s1_nxt.value  = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s1_r.act <= spmv_pkg::ACT_LOAD;
    end else begin
      s1_r.vld <= s1_nxt.vld;
      s1_r.act <= s1_nxt.act;
    end
    s1_r.in_rng <= s1_nxt.in_rng;
    s1_r.value  <= s1_nxt.value;
  end

  spmv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s1    (s1_r),
    .xdata ($signed(xdata)),
    .s2    (s2)
  );

  spmv_acc u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .s2             (s2),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_number (out_row_number),
    .out_row_value  (out_row_value),
    .out_overflow   (out_overflow)
  );

endmodule

[design/spmv_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spmv_checker: port-level checks for the sparse matrix-vector unit
// Watches the result channel for reset behavior, stalled-item stability and
// the row numbering sequence.
// ---------------------------------------------------------------------------
module spmv_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [spmv_pkg::ROW_W-1:0]         out_row_number,
  input logic signed [spmv_pkg::VAL_W-1:0]  out_row_value,
  input logic                               out_overflow
);

  logic [spmv_pkg::ROW_W-1:0] exp_row_r, exp_row_nxt;

  // advance the expected row number on every delivered result
  assign exp_row_nxt = (out_valid && out_ready) ? exp_row_r + 1'b1 : exp_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= '0;
    end else begin
      exp_row_r <= exp_row_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_number) &&
    $stable(out_row_value) && $stable(out_overflow))
    else $error("stalled result changed or dropped");

  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_number == exp_row_r)
    else $error("row number out of sequence");

endmodule

bind csr_sparse_matrix_vector_multiply spmv_checker u_spmv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_row_number (out_row_number),
  .out_row_value  (out_row_value),
  .out_overflow   (out_overflow)
);

[tb/csr_sparse_matrix_vector_multiply_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_tb: self-checking bench for the CSR SpMV
// A queue-fed driver pushes vector loads, nonzeros and row closes through the
// input channel with random gaps. A monitor stalls the result channel at
// random and compares every row sum with a Q16.16 shadow computed on accept.
// ---------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 1576;
  localparam int HOLD_START = 400;
  localparam int HOLD_LEN = 200;

  typedef struct {
    logic [1:0]                        action;
    logic [spmv_pkg::IDX_W-1:0]        index;
    logic signed [spmv_pkg::VAL_W-1:0] value;
    int                                gap;
  } spmv_item_t;

  typedef struct {
    logic [spmv_pkg::ROW_W-1:0]        row_number;
    logic signed [spmv_pkg::VAL_W-1:0] row_value;
    logic                              overflow;
  } row_sum_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        in_action = spmv_pkg::ACT_LOAD;
  logic [spmv_pkg::IDX_W-1:0]        in_index = '0;
  logic signed [spmv_pkg::VAL_W-1:0] in_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [spmv_pkg::ROW_W-1:0]        out_row_number;
  logic signed [spmv_pkg::VAL_W-1:0] out_row_value;
  logic                              out_overflow;

  csr_sparse_matrix_vector_multiply dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_number (out_row_number),
    .out_row_value  (out_row_value),
    .out_overflow   (out_overflow)
  );

  always #5 clk = ~clk;

  spmv_item_t pending_items[$];
  row_sum_t   row_sums_due[$];
  int         n_items;
  int         n_accepted;
  int         n_errors;

  // Shadow of the block state
  logic signed [spmv_pkg::VAL_W-1:0] x_shadow [spmv_pkg::VEC_DEPTH];
  logic signed [spmv_pkg::ACC_W-1:0] acc_shadow;
  logic [spmv_pkg::ROW_W-1:0]        row_shadow;
  logic                              sat_shadow;

  // Generator bookkeeping: columns already loaded in queue order
  int  loaded_cols[$];
  bit  col_loaded [spmv_pkg::VEC_DEPTH];

  function automatic void apply_item(spmv_item_t it);
    logic signed [spmv_pkg::ACC_W-1:0] prod;
    logic signed [spmv_pkg::ACC_W-1:0] sum;
    logic signed [spmv_pkg::ACC_W-1:0] q;
    row_sum_t                          rs;
    case (it.action)
      spmv_pkg::ACT_LOAD: begin
        x_shadow[it.index] = it.value;
      end
      spmv_pkg::ACT_MAC: begin
        prod = spmv_pkg::ACC_W'(it.value) * spmv_pkg::ACC_W'(x_shadow[it.index]);
        sum = acc_shadow + prod;
        if (acc_shadow[spmv_pkg::ACC_W-1] == prod[spmv_pkg::ACC_W-1] &&
            sum[spmv_pkg::ACC_W-1] != acc_shadow[spmv_pkg::ACC_W-1]) begin
          sat_shadow = 1'b1;
          sum = acc_shadow[spmv_pkg::ACC_W-1] ? {1'b1, {(spmv_pkg::ACC_W-1){1'b0}}}
                                              : {1'b0, {(spmv_pkg::ACC_W-1){1'b1}}};
        end
        acc_shadow = sum;
      end
      spmv_pkg::ACT_CLOSE: begin
        // arithmetic shift floors toward minus infinity
        q = acc_shadow >>> spmv_pkg::FRAC_W;
        rs.overflow = sat_shadow;
        if (q > 64'sd2147483647) begin
          q = 64'sd2147483647;
          rs.overflow = 1'b1;
        end else if (q < -64'sd2147483648) begin
          q = -64'sd2147483648;
          rs.overflow = 1'b1;
        end
        rs.row_number = row_shadow;
        rs.row_value = q[spmv_pkg::VAL_W-1:0];
        row_sums_due.push_back(rs);
        row_shadow = row_shadow + 1'b1;
        acc_shadow = '0;
        sat_shadow = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic add_item(logic [1:0] act, int idx, logic [31:0] val, int gap);
    spmv_item_t it;
    it.action = act;
    it.index = spmv_pkg::IDX_W'(idx);
    it.value = val;
    it.gap = gap;
    if (act == spmv_pkg::ACT_LOAD && !col_loaded[idx]) begin
      col_loaded[idx] = 1'b1;
      loaded_cols.push_back(idx);
    end
    pending_items.push_back(it);
    n_items++;
  endtask

  function automatic logic [31:0] pick_value();
    int s;
    logic [31:0] corners [5];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
    case ($urandom_range(0, 3))
      0, 1: begin
        s = int'($urandom_range(0, 2097151)) - 1048576;
        pick_value = s;
      end
      2: pick_value = $urandom;
      default: pick_value = corners[$urandom_range(0, 4)];
    endcase
  endfunction

  // Driver: offer the next item after its drawn gap, hold until accepted
  spmv_item_t offer;
  int         tx_idle;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_idle <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        apply_item(offer);
        n_accepted++;
      end
      if (pending_items.size() > 0 && tx_idle >= pending_items[0].gap) begin
        offer = pending_items.pop_front();
        in_action <= offer.action;
        in_index <= offer.index;
        in_value <= offer.value;
        in_valid <= 1'b1;
        tx_idle <= 0;
      end else begin
        in_valid <= 1'b0;
        if (pending_items.size() > 0)
          tx_idle <= tx_idle + 1;
      end
    end
  end

  // Long hold-off window so close-row items back up into the input
  int hold_cycles;
  bit rx_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      rx_hold <= 1'b0;
    end else begin
      hold_cycles <= hold_cycles + 1;
      rx_hold <= (hold_cycles >= HOLD_START) && (hold_cycles < HOLD_START + HOLD_LEN);
    end
  end

  // Monitor: random stall per result, dropped entirely during the hold-off
  int n_results;
  int rx_gap;
  int rx_idle;
  bit rx_fast;

  always @(posedge clk) begin
    row_sum_t rs;
    int       g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      rx_idle <= 0;
      rx_fast <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (row_sums_due.size() == 0) begin
        $error("unexpected result: row_number %0d row_value %0d overflow %0b",
               out_row_number, out_row_value, out_overflow);
        n_errors++;
      end else begin
        rs = row_sums_due.pop_front();
        if (out_row_number !== rs.row_number) begin
          $error("row_number: expected %0d actual %0d", rs.row_number, out_row_number);
          n_errors++;
        end
        if (out_row_value !== rs.row_value) begin
          $error("row_value: expected %0d actual %0d", rs.row_value, out_row_value);
          n_errors++;
        end
        if (out_overflow !== rs.overflow) begin
          $error("overflow: expected %0b actual %0b", rs.overflow, out_overflow);
          n_errors++;
        end
      end
      n_results++;
      if (n_results % 40 == 0)
        rx_fast <= ($urandom_range(0, 3) == 0);
      g = rx_fast ? 0 : int'($urandom_range(0, 6));
      rx_gap <= g;
      rx_idle <= 0;
      out_ready <= (g == 0 && !rx_hold);
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (rx_idle >= rx_gap) begin
      out_ready <= 1'b1;
    end else begin
      rx_idle <= rx_idle + 1;
      out_ready <= 1'b0;
    end
  end

  // Stimulus and end of run
  initial begin
    int  n_rand;
    int  n_mac;
    int  gap;
    bit  fast;
    acc_shadow = '0;
    row_shadow = '0;
    sat_shadow = 1'b0;

    // empty row closes to zero
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    add_item(spmv_pkg::ACT_LOAD, 0, 32'h8000_0000, 1);
    add_item(spmv_pkg::ACT_LOAD, 1023, 32'h7FFF_FFFF, 0);
    add_item(spmv_pkg::ACT_LOAD, 1, 32'h0000_0001, 2);
    add_item(spmv_pkg::ACT_LOAD, 682, 32'h0001_0000, 0);
    add_item(spmv_pkg::ACT_LOAD, 341, 32'hFFFF_0000, 0);
    // 2.5 * 1.0 + 1.0 * -1.0
    add_item(spmv_pkg::ACT_MAC, 682, 32'h0002_8000, 0);
    add_item(spmv_pkg::ACT_MAC, 341, 32'h0001_0000, 3);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    // tiny negative product rounds down to -1 lsb
    add_item(spmv_pkg::ACT_MAC, 1, 32'hFFFF_FFFF, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    // accumulator saturates high
    add_item(spmv_pkg::ACT_MAC, 0, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_MAC, 0, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    // accumulator saturates low
    add_item(spmv_pkg::ACT_MAC, 1023, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_MAC, 1023, 32'h8000_0000, 1);
    add_item(spmv_pkg::ACT_MAC, 1023, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    // output conversion saturates high, then low
    add_item(spmv_pkg::ACT_MAC, 0, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);
    add_item(spmv_pkg::ACT_MAC, 1023, 32'h8000_0000, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 4);
    // unused action code changes nothing
    add_item(ACT_UNUSED, 1023, 32'hFFFF_FFFF, 0);
    add_item(spmv_pkg::ACT_CLOSE, 0, 32'h0, 0);

    // random rows in compressed-row order, with reloads and some noise
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      fast = ($urandom_range(0, 4) == 0);
      if (n_rand == 0 || $urandom_range(0, 7) == 0) begin
        for (int i = $urandom_range(4, 32); i > 0; i--) begin
          gap = fast ? 0 : int'($urandom_range(0, 6));
          add_item(spmv_pkg::ACT_LOAD, int'($urandom_range(0, 1023)), pick_value(), gap);
          n_rand++;
        end
      end
      n_mac = $urandom_range(0, 8);
      for (int i = 0; i < n_mac; i++) begin
        gap = fast ? 0 : int'($urandom_range(0, 6));
        case ($urandom_range(0, 19))
          0: add_item(ACT_UNUSED, int'($urandom_range(0, 1023)), $urandom, gap);
          1: add_item(spmv_pkg::ACT_LOAD, int'($urandom_range(0, 1023)), pick_value(), gap);
          default: add_item(spmv_pkg::ACT_MAC,
                            loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
                            pick_value(), gap);
        endcase
        n_rand++;
      end
      gap = fast ? 0 : int'($urandom_range(0, 6));
      add_item(spmv_pkg::ACT_CLOSE, int'($urandom_range(0, 1023)), $urandom, gap);
      n_rand++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_items) @(posedge clk);
    while (row_sums_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[csr_sparse_matrix_vector_multiply.f]
design/spmv_pkg.sv
design/spmv_ram.sv
design/spmv_mul.sv
design/spmv_acc.sv
design/csr_sparse_matrix_vector_multiply.sv
design/spmv_checker.sv
tb/csr_sparse_matrix_vector_multiply_tb.sv
